// ===== hw/rtl/gpmr_pkg.sv =====
// Shared types and constants of the grid pattern match-and-rewrite block.
package gpmr_pkg;

    // Operation codes carried by s_operation
    localparam logic [2:0] OP_WR_SRC  = 3'd0;
    localparam logic [2:0] OP_WR_MASK = 3'd1;
    localparam logic [2:0] OP_WR_OUT  = 3'd2;
    localparam logic [2:0] OP_MATCH   = 3'd3;
    localparam logic [2:0] OP_RD_RES  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_GRID_W  = 3'd0;
    localparam logic [2:0] REG_GRID_H  = 3'd1;
    localparam logic [2:0] REG_PIN_W   = 3'd2;
    localparam logic [2:0] REG_PIN_H   = 3'd3;
    localparam logic [2:0] REG_POUT_W  = 3'd4;
    localparam logic [2:0] REG_POUT_H  = 3'd5;

    // Field widths
    localparam int OP_W       = 3;
    localparam int IDX_W      = 10;
    localparam int POS_W      = 10;
    localparam int COLOUR_W   = 4;
    localparam int MASK_W     = 16;
    localparam int DIM_W      = 11;
    localparam int PDIM_W     = 3;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int ENTRY_W    = COLOUR_W + 1;
    localparam int KEEP_BIT   = COLOUR_W;

    // Reset values of the configuration registers
    localparam logic [DIM_W-1:0]  GRID_DIM_RST = 11'd32;
    localparam logic [PDIM_W-1:0] PAT_DIM_RST  = 3'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic mul;
        logic walk_init;
        logic walk_next;
        logic walk_out;
        logic copy_init;
        logic copy_step;
        logic res_load;
        logic res_matched;
        logic res_read;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic fit;
        logic in_empty;
        logic out_empty;
        logic cells_zero;
        logic mask_ok;
        logic test_last;
        logic out_last;
        logic copy_last;
    } sts_t;

endpackage

// ===== hw/rtl/grid_pattern_match_rewrite.sv =====
// Top level of the grid pattern match-and-rewrite block.
// Usage:
//   Input words (s_*) carry one operation each: load a source cell, load a
//   window mask, load an output pattern entry, match-apply at (pos_x, pos_y),
//   or read a result grid cell. Every input word gives exactly one result
//   word (m_matched, m_read_colour) on the m_* channel.
//   Loads answer in the cycle after acceptance; a read passes through the
//   result read state first. Match-apply checks each window cell against
//   its allowed-colour mask, copies all grid_width*grid_height cells one
//   per cycle through the single source grid read port, then writes the
//   output pattern. One word is worked on at a time; the next is taken
//   once the result register is free or is being taken in the same cycle.
//   A stalled receiver holds the result in the output register and blocks
//   new input words. Configuration (cfg_*) is to be written only while
//   idle (the block itself does not enforce this) and is always ready.
//   Reset returns control state, result valid and config registers to
//   their defaults; grids and pattern stores stay undefined until written.
module grid_pattern_match_rewrite #(
    parameter int GRID_CELLS       = 1024,
    parameter int MAX_PATTERN_SIDE = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gpmr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gpmr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [gpmr_pkg::OP_W-1:0]        s_operation,
    input  logic [gpmr_pkg::IDX_W-1:0]       s_cell_index,
    input  logic [gpmr_pkg::POS_W-1:0]       s_pos_x,
    input  logic [gpmr_pkg::POS_W-1:0]       s_pos_y,
    input  logic [gpmr_pkg::COLOUR_W-1:0]    s_colour,
    input  logic [gpmr_pkg::MASK_W-1:0]      s_allow_mask,
    input  logic                             s_keep_cell,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_matched,
    output logic [gpmr_pkg::COLOUR_W-1:0]    m_read_colour
);
    import gpmr_pkg::*;

    cmd_t cmd;
    sts_t st;

    assign cfg_ready = 1'b1;

    gpmr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    gpmr_datapath #(
        .GRID_CELLS       (GRID_CELLS),
        .MAX_PATTERN_SIDE (MAX_PATTERN_SIDE)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_operation   (s_operation),
        .s_cell_index  (s_cell_index),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_colour      (s_colour),
        .s_allow_mask  (s_allow_mask),
        .s_keep_cell   (s_keep_cell),
        .cmd           (cmd),
        .st            (st),
        .m_matched     (m_matched),
        .m_read_colour (m_read_colour)
    );

    // No new word while a result is stuck at the output
    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("input taken while result stalled");

    // Load words answer in the next cycle
    a_load_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_operation == OP_WR_SRC || s_operation == OP_WR_MASK
         || s_operation == OP_WR_OUT)) |=> m_valid)
        else $error("load word gave no result");

    // Read words answer once the result read state has passed
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_operation == OP_RD_RES) |=> ##1 m_valid)
        else $error("read word gave no result");

    // Copy and pattern writes never share the result grid port
    a_single_result_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.copy_step |-> !(cmd.walk_next && cmd.walk_out))
        else $error("copy overlaps pattern write");

endmodule

// ===== hw/rtl/gpmr_ctrl.sv =====
// Sequencing state machine of the grid pattern match-and-rewrite block.
module gpmr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  gpmr_pkg::sts_t st,
    output gpmr_pkg::cmd_t cmd
);
    import gpmr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDRES = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_FIT   = 4'd3;
    localparam logic [3:0] S_TRD   = 4'd4;
    localparam logic [3:0] S_TCHK  = 4'd5;
    localparam logic [3:0] S_COPY  = 4'd6;
    localparam logic [3:0] S_DRAIN = 4'd7;
    localparam logic [3:0] S_OUTW  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.accept = 1'b1;
                    case (st.op)
                        OP_RD_RES: state_next = S_RDRES;
                        OP_MATCH:  state_next = S_MUL;
                        default: begin
                            cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_RDRES: begin
                cmd.res_load = 1'b1;
                cmd.res_read = 1'b1;
                state_next   = S_IDLE;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_FIT;
            end
            S_FIT: begin
                if (!st.fit) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end else if (!st.in_empty) begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_TRD;
                end else if (!st.cells_zero) begin
                    cmd.copy_init = 1'b1;
                    state_next    = S_COPY;
                end else if (st.out_empty) begin
                    cmd.res_load    = 1'b1;
                    cmd.res_matched = 1'b1;
                    state_next      = S_IDLE;
                end else begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_OUTW;
                end
            end
            S_TRD: begin
                state_next = S_TCHK;
            end
            S_TCHK: begin
                if (!st.mask_ok) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end else if (!st.test_last) begin
                    cmd.walk_next = 1'b1;
                    state_next    = S_TRD;
                end else if (!st.cells_zero) begin
                    cmd.copy_init = 1'b1;
                    state_next    = S_COPY;
                end else if (st.out_empty) begin
                    cmd.res_load    = 1'b1;
                    cmd.res_matched = 1'b1;
                    state_next      = S_IDLE;
                end else begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_OUTW;
                end
            end
            S_COPY: begin
                cmd.copy_step = 1'b1;
                if (st.copy_last) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (st.out_empty) begin
                    cmd.res_load    = 1'b1;
                    cmd.res_matched = 1'b1;
                    state_next      = S_IDLE;
                end else begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_OUTW;
                end
            end
            S_OUTW: begin
                cmd.walk_next = 1'b1;
                cmd.walk_out  = 1'b1;
                if (st.out_last) begin
                    cmd.res_load    = 1'b1;
                    cmd.res_matched = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result word valid: set on load, cleared when taken
    always_comb begin
        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/gpmr_datapath.sv =====
// Stores, address walkers and result register of the grid pattern block.
module gpmr_datapath #(
    parameter int GRID_CELLS       = 1024,
    parameter int MAX_PATTERN_SIDE = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [gpmr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gpmr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [gpmr_pkg::OP_W-1:0]        s_operation,
    input  logic [gpmr_pkg::IDX_W-1:0]       s_cell_index,
    input  logic [gpmr_pkg::POS_W-1:0]       s_pos_x,
    input  logic [gpmr_pkg::POS_W-1:0]       s_pos_y,
    input  logic [gpmr_pkg::COLOUR_W-1:0]    s_colour,
    input  logic [gpmr_pkg::MASK_W-1:0]      s_allow_mask,
    input  logic                             s_keep_cell,
    input  gpmr_pkg::cmd_t                   cmd,
    output gpmr_pkg::sts_t                   st,
    output logic                             m_matched,
    output logic [gpmr_pkg::COLOUR_W-1:0]    m_read_colour
);
    import gpmr_pkg::*;

    localparam int AW    = $clog2(GRID_CELLS);
    localparam int CW    = AW + 1;
    localparam int SLOTS = MAX_PATTERN_SIDE * MAX_PATTERN_SIDE;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Configuration registers
    logic [DIM_W-1:0]  gw_reg, gh_reg;
    logic [PDIM_W-1:0] piw_reg, pih_reg, pow_reg, poh_reg;

    // Stores
    logic [COLOUR_W-1:0] src_mem [GRID_CELLS];
    logic [COLOUR_W-1:0] res_mem [GRID_CELLS];
    logic [MASK_W-1:0]   mask_mem [SLOTS];
    logic [ENTRY_W-1:0]  ent_mem [SLOTS];

    // Captured request
    logic [POS_W-1:0] px_reg, py_reg;
    logic             rd_ok_reg;

    // Walk state
    logic [PROD_W-1:0]   cells_reg, base_reg, row_reg;
    logic [PDIM_W-1:0]   dx_reg, dy_reg;
    logic [SW-1:0]       slot_reg;
    logic [CW-1:0]       cnt_reg;
    logic                cp_valid_reg;
    logic [AW-1:0]       cp_addr_reg;
    logic [COLOUR_W-1:0] src_rdata_reg, res_rdata_reg;

    logic              idx_in_grid, idx_in_pat;
    logic              src_rd_en;
    logic [AW-1:0]     src_raddr;
    logic [AW-1:0]     win_addr;
    logic [PDIM_W-1:0] walk_w, walk_h;
    logic              walk_row_end;
    logic [DIM_W:0]    out_col, out_row;
    logic [ENTRY_W-1:0] cur_entry;
    logic              out_wr;
    logic [AW-1:0]     out_addr;

    assign idx_in_grid = 32'(s_cell_index) < 32'(GRID_CELLS);
    assign idx_in_pat  = 32'(s_cell_index) < 32'(SLOTS);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg  <= GRID_DIM_RST;
            gh_reg  <= GRID_DIM_RST;
            piw_reg <= PAT_DIM_RST;
            pih_reg <= PAT_DIM_RST;
            pow_reg <= PAT_DIM_RST;
            poh_reg <= PAT_DIM_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GRID_W: gw_reg  <= cfg_data[DIM_W-1:0];
                REG_GRID_H: gh_reg  <= cfg_data[DIM_W-1:0];
                REG_PIN_W:  piw_reg <= cfg_data[PDIM_W-1:0];
                REG_PIN_H:  pih_reg <= cfg_data[PDIM_W-1:0];
                REG_POUT_W: pow_reg <= cfg_data[PDIM_W-1:0];
                REG_POUT_H: poh_reg <= cfg_data[PDIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            px_reg    <= s_pos_x;
            py_reg    <= s_pos_y;
            rd_ok_reg <= idx_in_grid;
        end
    end

    // Pattern stores
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_operation == OP_WR_MASK && idx_in_pat) begin
            mask_mem[SW'(s_cell_index)] <= s_allow_mask;
        end
        if (cmd.accept && s_operation == OP_WR_OUT && idx_in_pat) begin
            ent_mem[SW'(s_cell_index)] <= {s_keep_cell, s_colour};
        end
    end

    // Grid area and window row base
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            cells_reg <= PROD_W'(gw_reg) * PROD_W'(gh_reg);
            base_reg  <= PROD_W'(py_reg) * PROD_W'(gw_reg);
        end
    end

    // Window walk over input window or output pattern
    assign walk_w       = cmd.walk_out ? pow_reg : piw_reg;
    assign walk_h       = cmd.walk_out ? poh_reg : pih_reg;
    assign walk_row_end = ({1'b0, dx_reg} + 4'd1) == {1'b0, walk_w};

    always_ff @(posedge aclk) begin
        if (cmd.walk_init) begin
            dx_reg   <= '0;
            dy_reg   <= '0;
            slot_reg <= '0;
            row_reg  <= base_reg;
        end else if (cmd.walk_next) begin
            slot_reg <= slot_reg + SW'(1);
            if (walk_row_end) begin
                dx_reg  <= '0;
                dy_reg  <= dy_reg + PDIM_W'(1);
                row_reg <= row_reg + PROD_W'(gw_reg);
            end else begin
                dx_reg <= dx_reg + PDIM_W'(1);
            end
        end
    end

    assign win_addr = AW'(row_reg + PROD_W'(px_reg) + PROD_W'(dx_reg));

    // Copy counter and delayed write
    always_ff @(posedge aclk) begin
        if (cmd.copy_init) begin
            cnt_reg <= '0;
        end else if (cmd.copy_step) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
        cp_addr_reg <= AW'(cnt_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cp_valid_reg <= 1'b0;
        end else begin
            cp_valid_reg <= cmd.copy_step;
        end
    end

    // Source grid: write on load, read for test and copy
    assign src_rd_en = cmd.copy_step || (cmd.walk_init == 1'b0 && cmd.walk_next == 1'b0);
    assign src_raddr = cmd.copy_step ? AW'(cnt_reg) : win_addr;

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_operation == OP_WR_SRC && idx_in_grid) begin
            src_mem[AW'(s_cell_index)] <= s_colour;
        end
    end

    always_ff @(posedge aclk) begin
        if (src_rd_en) begin
            src_rdata_reg <= src_mem[src_raddr];
        end
    end

    // Output pattern placement
    assign cur_entry = ent_mem[slot_reg];
    assign out_col   = (DIM_W+1)'(px_reg) + (DIM_W+1)'(dx_reg);
    assign out_row   = (DIM_W+1)'(py_reg) + (DIM_W+1)'(dy_reg);
    assign out_wr    = cmd.walk_out && cmd.walk_next && !cur_entry[KEEP_BIT]
                       && out_col < (DIM_W+1)'(gw_reg) && out_row < (DIM_W+1)'(gh_reg);
    assign out_addr  = AW'(row_reg + PROD_W'(out_col));

    // Result grid: one write port, one read port
    always_ff @(posedge aclk) begin
        if (cp_valid_reg) begin
            res_mem[cp_addr_reg] <= src_rdata_reg;
        end else if (out_wr) begin
            res_mem[out_addr] <= cur_entry[COLOUR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_operation == OP_RD_RES) begin
            res_rdata_reg <= res_mem[AW'(s_cell_index)];
        end
    end

    // Result word payload
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_matched     <= cmd.res_matched;
            m_read_colour <= (cmd.res_read && rd_ok_reg) ? res_rdata_reg : '0;
        end
    end

    // Status
    always_comb begin
        st            = '0;
        st.op         = s_operation;
        st.fit        = cells_reg <= PROD_W'(GRID_CELLS)
                        && {1'b0, piw_reg} <= 4'(MAX_PATTERN_SIDE)
                        && {1'b0, pih_reg} <= 4'(MAX_PATTERN_SIDE)
                        && {1'b0, pow_reg} <= 4'(MAX_PATTERN_SIDE)
                        && {1'b0, poh_reg} <= 4'(MAX_PATTERN_SIDE)
                        && (12'(px_reg) + 12'(piw_reg)) <= 12'(gw_reg)
                        && (12'(py_reg) + 12'(pih_reg)) <= 12'(gh_reg);
        st.in_empty   = (piw_reg == '0) || (pih_reg == '0);
        st.out_empty  = (pow_reg == '0) || (poh_reg == '0);
        st.cells_zero = (cells_reg == '0);
        st.mask_ok    = mask_mem[slot_reg][src_rdata_reg];
        st.test_last  = (({1'b0, dx_reg} + 4'd1) == {1'b0, piw_reg})
                        && (({1'b0, dy_reg} + 4'd1) == {1'b0, pih_reg});
        st.out_last   = (({1'b0, dx_reg} + 4'd1) == {1'b0, pow_reg})
                        && (({1'b0, dy_reg} + 4'd1) == {1'b0, poh_reg});
        st.copy_last  = (PROD_W'(cnt_reg) + PROD_W'(1)) == cells_reg;
    end

endmodule
